[design/shell_line_tokenizer_assert.svh]
// Assertion macros used by the checker file
`ifndef SHELL_LINE_TOKENIZER_ASSERT_SVH
`define SHELL_LINE_TOKENIZER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define SLT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[design/slt_pkg.sv]
package slt_pkg;
   localparam int TOKEN_MAX_DEF = 63;
   localparam int FD_W = 31;

   localparam logic [2:0] RK_ARG  = 3'd0;
   localparam logic [2:0] RK_PATH = 3'd1;
   localparam logic [2:0] RK_PIPE = 3'd2;
   localparam logic [2:0] RK_NL   = 3'd3;
   localparam logic [2:0] RK_ERR  = 3'd4;

   localparam logic [2:0] ERR_NUL      = 3'd0;
   localparam logic [2:0] ERR_STOPPED  = 3'd1;
   localparam logic [2:0] ERR_REDIR2   = 3'd2;
   localparam logic [2:0] ERR_EMPTYPIPE = 3'd3;
   localparam logic [2:0] ERR_NOPATH   = 3'd4;
   localparam logic [2:0] ERR_TOOLONG  = 3'd5;

   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_BS  = 8'h5C;
   localparam logic [7:0] CH_SQ  = 8'h27;
   localparam logic [7:0] CH_DQ  = 8'h22;
   localparam logic [7:0] CH_GT  = 8'h3E;
   localparam logic [7:0] CH_LT  = 8'h3C;
   localparam logic [7:0] CH_PIPE = 8'h7C;
   localparam logic [7:0] CH_SP  = 8'd32;

   localparam logic [1:0] QM_NONE = 2'd0;
   localparam logic [1:0] QM_SQ   = 2'd1;
   localparam logic [1:0] QM_DQ   = 2'd2;

   // classified byte command passed from front to back
   typedef struct packed {
      logic       restart;
      logic       nul;
      logic [7:0] ch;
   } cmd_type;
endpackage

[design/slt_ram.sv]
module slt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 63
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[design/slt_front.sv]
// Input side: take items and queue them as commands (two-entry queue)
module slt_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_kind,
   input  logic [7:0]      req_char_in,
   output logic            cmd_valid,
   input  logic            cmd_ready,
   output slt_pkg::cmd_type cmd_data
);
   import slt_pkg::*;

   cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rp_ff, rp_in, wp_ff, wp_in;
   logic       push, pop;
   cmd_type    nc;

   always_comb begin
      nc.restart = req_kind;
      nc.nul     = (req_char_in == 8'd0);
      nc.ch      = req_char_in;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rp_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rp_in  = rp_ff ^ pop;
      wp_in  = wp_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rp_ff  <= 1'b0;
         wp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff  <= rp_in;
         wp_ff  <= wp_in;
      end
      if (push) begin
         q_ff[wp_ff] <= nc;
      end
   end
endmodule

[design/slt_back.sv]
// Command side: tokenizer state and sequenced result emission
module slt_back #(
   parameter int TOKEN_MAX = slt_pkg::TOKEN_MAX_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   output logic                    cmd_ready,
   input  slt_pkg::cmd_type        cmd_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_result_kind,
   output logic [7:0]              rsp_token_byte,
   output logic                    rsp_token_end,
   output logic [slt_pkg::FD_W-1:0] rsp_redirect_fd,
   output logic                    rsp_redirect_is_input,
   output logic                    rsp_command_kept,
   output logic [2:0]              rsp_error_code,
   output logic                    rsp_last
);
   import slt_pkg::*;

   localparam int AW = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;
   localparam int LW = $clog2(TOKEN_MAX + 1);
   localparam logic [LW-1:0] LEN_MAX = LW'(TOKEN_MAX);

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EXEC   = 4'd1;  // decide action for held byte
   localparam logic [3:0] S_DUMP   = 4'd2;  // waiting read latency
   localparam logic [3:0] S_DUMPB  = 4'd3;  // emit byte
   localparam logic [3:0] S_POST   = 4'd4;  // after token dump
   localparam logic [3:0] S_OUT    = 4'd5;  // hold result until transfer
   localparam logic [3:0] S_APP2   = 4'd6;  // second append (quoted byte after backslash)

   // what to do after a token dump
   localparam logic [2:0] P_NONE  = 3'd0;
   localparam logic [2:0] P_NL    = 3'd1;
   localparam logic [2:0] P_PIPE  = 3'd2;
   localparam logic [2:0] P_REDIR = 3'd3;  // finish while redirect pending, then retry
   localparam logic [2:0] P_REDGO = 3'd4;  // set redirection with default fd

   logic [3:0] st_ff, st_in;
   logic [2:0] post_ff, post_in;
   logic [7:0] ch_ff, ch_in;
   logic       esc_ff, esc_in;
   logic [1:0] qm_ff, qm_in;
   logic       done_ff, done_in, stop_ff, stop_in;
   logic [LW-1:0] len_ff, len_in, idx_ff, idx_in;
   logic [FD_W-1:0] num_ff, num_in, pfd_ff, pfd_in;
   logic       isnum_ff, isnum_in, rp_ff, rp_in, pin_ff, pin_in, arg_ff, arg_in;
   logic [7:0] app2_ff, app2_in;
   logic       ret_ff, ret_in;  // return to OUT->IDLE vs post after output

   // output register
   logic [2:0] ok_ff, ok_in;
   logic [7:0] ob_ff, ob_in;
   logic       oe_ff, oe_in;
   logic [FD_W-1:0] ofd_ff, ofd_in;
   logic       oin_ff, oin_in, okp_ff, okp_in, olast_ff, olast_in;
   logic [2:0] oerr_ff, oerr_in;

   logic       wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0] wr_data, rd_data;

   slt_ram #(.WIDTH(8), .DEPTH(TOKEN_MAX)) u_buf (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign cmd_ready = (st_ff == S_IDLE);
   assign rsp_valid = (st_ff == S_OUT);
   assign rsp_result_kind       = ok_ff;
   assign rsp_token_byte        = ob_ff;
   assign rsp_token_end         = oe_ff;
   assign rsp_redirect_fd       = ofd_ff;
   assign rsp_redirect_is_input = oin_ff;
   assign rsp_command_kept      = okp_ff;
   assign rsp_error_code        = oerr_ff;
   assign rsp_last              = olast_ff;
   assign rd_addr = idx_ff[AW-1:0];

   logic [34:0] num_x10;
   assign num_x10 = {1'b0, num_ff, 3'b000} + {3'b000, num_ff, 1'b0};

   always_comb begin
      logic       dig, append_ok, quoted;
      logic [7:0] ab;
      logic       do_app;
      logic [34:0] nv;
      logic [1:0] mine;

      st_in = st_ff; post_in = post_ff; ch_in = ch_ff; esc_in = esc_ff; qm_in = qm_ff;
      done_in = done_ff; stop_in = stop_ff; len_in = len_ff; idx_in = idx_ff;
      num_in = num_ff; pfd_in = pfd_ff; isnum_in = isnum_ff; rp_in = rp_ff;
      pin_in = pin_ff; arg_in = arg_ff; app2_in = app2_ff; ret_in = ret_ff;
      ok_in = ok_ff; ob_in = ob_ff; oe_in = oe_ff; ofd_in = ofd_ff; oin_in = oin_ff;
      okp_in = okp_ff; olast_in = olast_ff; oerr_in = oerr_ff;
      wr_en = 1'b0; wr_addr = len_ff[AW-1:0]; wr_data = 8'd0;
      do_app = 1'b0; ab = 8'd0; quoted = 1'b0; mine = QM_SQ; nv = '0;
      dig = 1'b0; append_ok = 1'b0;

      case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               ch_in = cmd_data.ch;
               ok_in = RK_ERR; ob_in = 8'd0; oe_in = 1'b0; ofd_in = '0; oin_in = 1'b0;
               okp_in = 1'b0; olast_in = 1'b1; ret_in = 1'b0;
               if (cmd_data.restart) begin
                  esc_in = 1'b0; qm_in = QM_NONE; done_in = 1'b0; stop_in = 1'b0;
                  len_in = '0; num_in = '0; isnum_in = 1'b0; rp_in = 1'b0;
                  pfd_in = '0; pin_in = 1'b0; arg_in = 1'b0;
               end else if (cmd_data.nul) begin
                  oerr_in = ERR_NUL; stop_in = 1'b1; st_in = S_OUT;
               end else if (stop_ff || done_ff) begin
                  oerr_in = ERR_STOPPED; stop_in = 1'b1; st_in = S_OUT;
               end else begin
                  st_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            st_in = S_IDLE;
            mine = (ch_ff == CH_SQ) ? QM_SQ : QM_DQ;
            case (ch_ff)
               CH_NL: begin
                  if (esc_ff) esc_in = 1'b0;
                  else if (qm_ff != QM_NONE) begin do_app = 1'b1; ab = ch_ff; end
                  else begin post_in = P_NL; idx_in = '0; st_in = S_DUMP; end
               end
               CH_BS: begin
                  if (esc_ff || qm_ff == QM_SQ) begin
                     esc_in = 1'b0; do_app = 1'b1; ab = ch_ff;
                  end else esc_in = 1'b1;
               end
               CH_SQ, CH_DQ: begin
                  esc_in = 1'b0;
                  if (esc_ff && qm_ff == QM_DQ && ch_ff == CH_SQ) begin
                     do_app = 1'b1; ab = CH_BS; app2_in = ch_ff;
                  end else if (esc_ff || (qm_ff != QM_NONE && qm_ff != mine)) begin
                     do_app = 1'b1; ab = ch_ff;
                  end else qm_in = (qm_ff == mine) ? QM_NONE : mine;
               end
               default: quoted = 1'b1;
            endcase
            if (quoted) begin
               if ((ch_ff == CH_GT || ch_ff == CH_LT) && !esc_ff && qm_ff == QM_NONE) begin
                  idx_in = '0;
                  if (rp_ff) begin
                     post_in = P_REDIR; st_in = S_DUMP;
                  end else if (len_ff != '0 && isnum_ff) begin
                     rp_in = 1'b1; pfd_in = num_ff; pin_in = (ch_ff == CH_LT);
                     len_in = '0; isnum_in = 1'b0; num_in = '0;
                  end else begin
                     post_in = P_REDGO; st_in = S_DUMP;
                  end
               end else if (ch_ff == CH_PIPE && !esc_ff && qm_ff == QM_NONE) begin
                  post_in = P_PIPE; idx_in = '0; st_in = S_DUMP;
               end else if (!esc_ff && qm_ff == QM_NONE && ch_ff <= CH_SP) begin
                  post_in = P_NONE; idx_in = '0; st_in = S_DUMP;
               end else begin
                  esc_in = 1'b0;
                  if (esc_ff && qm_ff == QM_DQ) begin
                     do_app = 1'b1; ab = CH_BS; app2_in = ch_ff;
                  end else begin
                     do_app = 1'b1; ab = ch_ff;
                  end
               end
            end
            // the two-append cases mark a second byte in app2
            if (do_app && ab == CH_BS && esc_ff && qm_ff == QM_DQ &&
                ch_ff != CH_BS && ch_ff != CH_DQ && ch_ff != CH_NL) begin
               st_in = S_APP2;
            end
         end
         S_APP2: begin
            do_app = 1'b1; ab = app2_ff; st_in = S_IDLE;
         end
         S_DUMP: begin
            // token dump: read latency cycle, or post actions when done
            if (idx_ff >= len_ff) begin
               st_in = S_POST;
            end else begin
               st_in = S_DUMPB;
            end
         end
         S_DUMPB: begin
            ok_in = rp_ff ? RK_PATH : RK_ARG; ob_in = rd_data;
            oe_in = (idx_ff + 1'b1 == len_ff); ofd_in = rp_ff ? pfd_ff : '0;
            oin_in = rp_ff & pin_ff; okp_in = 1'b0; oerr_in = 3'd0;
            // only a command end puts another result behind the token
            olast_in = oe_in && !(post_ff == P_NL || post_ff == P_PIPE);
            idx_in = idx_ff + 1'b1; ret_in = 1'b1; st_in = S_OUT;
         end
         S_POST: begin
            // finish_token bookkeeping if a token was dumped
            if (len_ff != '0) begin
               if (!rp_ff) arg_in = 1'b1;
               len_in = '0; isnum_in = 1'b0; num_in = '0;
               rp_in = 1'b0; pfd_in = '0; pin_in = 1'b0;
            end
            ok_in = RK_ERR; ob_in = 8'd0; oe_in = 1'b0; ofd_in = '0; oin_in = 1'b0;
            okp_in = 1'b0; olast_in = 1'b1; ret_in = 1'b0; oerr_in = 3'd0;
            st_in = S_IDLE;
            case (post_ff)
               P_NL, P_PIPE: begin
                  if (rp_ff && len_ff == '0) begin
                     oerr_in = ERR_NOPATH; stop_in = 1'b1; st_in = S_OUT;
                  end else if (arg_ff || (len_ff != '0 && !rp_ff)) begin
                     ok_in = (post_ff == P_NL) ? RK_NL : RK_PIPE; okp_in = 1'b1;
                     arg_in = 1'b0; st_in = S_OUT;
                     if (post_ff == P_NL) done_in = 1'b1;
                  end else if (post_ff == P_PIPE) begin
                     oerr_in = ERR_EMPTYPIPE; stop_in = 1'b1; st_in = S_OUT;
                  end else begin
                     ok_in = RK_NL; done_in = 1'b1; st_in = S_OUT;
                  end
               end
               P_REDIR: begin
                  if (len_ff == '0) begin
                     oerr_in = ERR_REDIR2; stop_in = 1'b1; st_in = S_OUT;
                  end else begin
                     rp_in = 1'b1; pin_in = (ch_ff == CH_LT);
                     pfd_in = (ch_ff == CH_GT) ? FD_W'(1) : '0;
                  end
               end
               P_REDGO: begin
                  rp_in = 1'b1; pin_in = (ch_ff == CH_LT);
                  pfd_in = (ch_ff == CH_GT) ? FD_W'(1) : '0;
               end
               default: ;
            endcase
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (ret_ff) begin
                  st_in = (idx_ff >= len_ff) ? S_POST : S_DUMPB;
               end else st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase

      if (do_app) begin
         dig = (ab >= 8'h30) && (ab <= 8'h39);
         append_ok = (len_ff < LEN_MAX);
         if (!append_ok) begin
            ok_in = RK_ERR; ob_in = 8'd0; oe_in = 1'b0; ofd_in = '0; oin_in = 1'b0;
            okp_in = 1'b0; olast_in = 1'b1; ret_in = 1'b0; oerr_in = ERR_TOOLONG;
            stop_in = 1'b1; st_in = S_OUT;
         end else begin
            wr_en = 1'b1; wr_data = ab; len_in = len_ff + 1'b1;
            nv = num_x10 + {31'd0, ab[3:0]};
            if (len_ff == '0) begin
               isnum_in = dig; num_in = dig ? FD_W'(ab[3:0]) : '0;
            end else if (isnum_ff && dig && !(len_ff == LW'(1) && num_ff == '0)) begin
               if (nv > 35'h7FFFFFFF) begin isnum_in = 1'b0; num_in = '0; end
               else num_in = nv[FD_W-1:0];
            end else begin
               isnum_in = 1'b0; num_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; esc_ff <= 1'b0; qm_ff <= QM_NONE; done_ff <= 1'b0;
         stop_ff <= 1'b0; len_ff <= '0; num_ff <= '0; isnum_ff <= 1'b0;
         rp_ff <= 1'b0; pfd_ff <= '0; pin_ff <= 1'b0; arg_ff <= 1'b0;
      end else begin
         st_ff <= st_in; esc_ff <= esc_in; qm_ff <= qm_in; done_ff <= done_in;
         stop_ff <= stop_in; len_ff <= len_in; num_ff <= num_in; isnum_ff <= isnum_in;
         rp_ff <= rp_in; pfd_ff <= pfd_in; pin_ff <= pin_in; arg_ff <= arg_in;
      end
      post_ff <= post_in; ch_ff <= ch_in; idx_ff <= idx_in; app2_ff <= app2_in;
      ret_ff <= ret_in; ok_ff <= ok_in; ob_ff <= ob_in; oe_ff <= oe_in;
      ofd_ff <= ofd_in; oin_ff <= oin_in; okp_ff <= okp_in; olast_ff <= olast_in;
      oerr_ff <= oerr_in;
   end
endmodule

[design/shell_line_tokenizer.sv]
// Channel | Direction | Signals
// req     | in        | req_valid/req_ready, req_kind, req_char_in
// rsp     | out       | rsp_valid/rsp_ready, rsp_result_kind ... rsp_last
// An ordinary byte passes IDLE (accept) and EXEC (execute) in the command sequencer,
// plus APP2 when a backslash is kept in front of it; a byte rejected on accept goes to OUT.
// A token dump reads the first buffer byte in DUMP, then DUMPB (load) and OUT (output)
// per emitted token byte, and POST to finish; every result waits for its transfer.
// A two-entry queue lets the input side take up to two bytes while results stall.
// Reset is synchronous and clears all tokenizer state; the buffer needs no clear.
module shell_line_tokenizer #(
   parameter int TOKEN_MAX = slt_pkg::TOKEN_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic [7:0]               req_char_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_result_kind,
   output logic [7:0]               rsp_token_byte,
   output logic                     rsp_token_end,
   output logic [slt_pkg::FD_W-1:0] rsp_redirect_fd,
   output logic                     rsp_redirect_is_input,
   output logic                     rsp_command_kept,
   output logic [2:0]               rsp_error_code,
   output logic                     rsp_last
);
   import slt_pkg::*;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;

   slt_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_char_in(req_char_in), .cmd_valid(cmd_valid),
      .cmd_ready(cmd_ready), .cmd_data(cmd_data)
   );

   slt_back #(.TOKEN_MAX(TOKEN_MAX)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd_data(cmd_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind), .rsp_token_byte(rsp_token_byte),
      .rsp_token_end(rsp_token_end), .rsp_redirect_fd(rsp_redirect_fd),
      .rsp_redirect_is_input(rsp_redirect_is_input),
      .rsp_command_kept(rsp_command_kept), .rsp_error_code(rsp_error_code),
      .rsp_last(rsp_last)
   );
endmodule

[design/slt_checker.sv]
`include "shell_line_tokenizer_assert.svh"
module slt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_result_kind,
   input logic [7:0]  rsp_token_byte,
   input logic        rsp_token_end,
   input logic [2:0]  rsp_error_code,
   input logic        rsp_last
);
   import slt_pkg::*;

   `SLT_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_token_byte), "result dropped while stalled")
   `SLT_ASSERT_IMP(a_err_last, clock, reset, rsp_valid && rsp_result_kind == RK_ERR, rsp_last, "error not last")
   `SLT_ASSERT_IMP(a_kind, clock, reset, rsp_valid, rsp_result_kind <= RK_ERR, "bad kind")
   `SLT_ASSERT_IMP(a_last_tok, clock, reset, rsp_valid && rsp_last && (rsp_result_kind == RK_ARG || rsp_result_kind == RK_PATH), rsp_token_end, "token cut")
   `SLT_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_result_kind != RK_ERR, rsp_error_code == '0, "error code on a non-error result")
endmodule

bind shell_line_tokenizer slt_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_result_kind(rsp_result_kind), .rsp_token_byte(rsp_token_byte),
   .rsp_token_end(rsp_token_end), .rsp_error_code(rsp_error_code), .rsp_last(rsp_last)
);
